// ----- rtl/cjtm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cjtm_pkg: shared types and constants for the cron job table matcher
// Field widths, wildcard codes, result status codes and the stored entry.
// ---------------------------------------------------------------------------
package cjtm_pkg;

  localparam int MIN_W = 6;
  localparam int HOUR_W = 5;
  localparam int DOM_W = 6;
  localparam int MON_W = 4;
  localparam int DOW_W = 4;
  localparam int STATUS_W = 2;
  localparam int INDEX_W = 4;
  localparam int FOUND_W = 5;

  localparam logic [MIN_W-1:0] WILD_MIN = 6'd63;
  localparam logic [HOUR_W-1:0] WILD_HOUR = 5'd31;
  localparam logic [DOM_W-1:0] WILD_DOM = 6'd63;
  localparam logic [MON_W-1:0] WILD_MON = 4'd15;
  localparam logic [DOW_W-1:0] WILD_DOW = 4'd15;
  localparam logic [DOW_W-1:0] DOW_SUN7 = 4'd7;

  // a tick reports at most this many matches
  localparam logic [FOUND_W-1:0] RES_LIMIT = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_MATCH = 2'd2,
    ST_NONE  = 2'd3
  } cjtm_status_t;

  typedef struct packed {
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [DOM_W-1:0]  dom;
    logic [MON_W-1:0]  month;
    logic [DOW_W-1:0]  weekday;
    logic              action;
  } cjtm_entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr;     // store the request as this cell's entry
    logic load;   // capture the match flag for the current tick
    logic shift;  // take the neighbor's match flag
  } cjtm_cell_ctl_t;

  // weekday 7 is Sunday, same as 0
  function automatic logic [DOW_W-1:0] norm_dow(input logic [DOW_W-1:0] d);
    norm_dow = (d == DOW_SUN7) ? '0 : d;
  endfunction

endpackage : cjtm_pkg
`default_nettype wire

// ----- rtl/cjtm_req_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cjtm_req_if: request channel
// valid/ready handshake carrying one add or tick request per beat.
// ---------------------------------------------------------------------------
interface cjtm_req_if import cjtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [MIN_W-1:0]  minute_value;
  logic [HOUR_W-1:0] hour_value;
  logic [DOM_W-1:0]  day_of_month_value;
  logic [MON_W-1:0]  month_value;
  logic [DOW_W-1:0]  weekday_value;
  logic              has_action;

  modport source (
    output valid, req_type, minute_value, hour_value, day_of_month_value,
           month_value, weekday_value, has_action,
    input  ready
  );
  modport sink (
    input  valid, req_type, minute_value, hour_value, day_of_month_value,
           month_value, weekday_value, has_action,
    output ready
  );
endinterface : cjtm_req_if
`default_nettype wire

// ----- rtl/cjtm_rsp_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cjtm_rsp_if: result channel
// valid/ready handshake carrying one result per beat.
// ---------------------------------------------------------------------------
interface cjtm_rsp_if import cjtm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  job_index;
  logic                last;

  modport source (output valid, status, job_index, last, input ready);
  modport sink (input valid, status, job_index, last, output ready);
endinterface : cjtm_rsp_if
`default_nettype wire

// ----- rtl/cjtm_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cjtm_cell: one job table slot
// Holds one entry, compares it against the tick time, and passes its match
// flag down the chain toward slot 0 during a scan.
// ---------------------------------------------------------------------------
module cjtm_cell import cjtm_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire cjtm_cell_ctl_t ctl,
  input  wire cjtm_entry_t    din,
  input  wire                 hit_in,
  output logic                hit_out
);

  cjtm_entry_t entry;
  logic        hit;
  logic        match;

  always_comb begin
    match = entry.action
      && (entry.minute == WILD_MIN || entry.minute == din.minute)
      && (entry.hour == WILD_HOUR || entry.hour == din.hour)
      && (entry.dom == WILD_DOM || entry.dom == din.dom)
      && (entry.month == WILD_MON || entry.month == din.month)
      && (entry.weekday == WILD_DOW
          || norm_dow(entry.weekday) == norm_dow(din.weekday));
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      entry <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.load) begin
      hit <= match;
    end else if (ctl.shift) begin
      hit <= hit_in;
    end
  end

  assign hit_out = hit;

endmodule : cjtm_cell
`default_nettype wire

// ----- rtl/cron_job_table_matcher_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cron_job_table_matcher_top: cron job table with in-order tick matching
// Row of job cells plus a scan sequencer and a registered result stage.
// ---------------------------------------------------------------------------
// An add request is written into the next free cell and answered with
// "added" and its index, or "full" once MAX_JOBS are held. A tick request
// makes every cell compare its entry with the time in the same cycle; the
// match flags then shift toward cell 0, one cell per cycle unless a held hit
// waits for a free result slot, and the sequencer reports hits in insertion
// order. From its accept to the next accept a tick occupies the block for
// capture, one shift per stored job, the end-of-scan check and the closing
// result, and waits while the result side stalls. One hit is held back until
// the next one or the end of the scan is seen, so the closing result carries
// the last mark; a tick with no hits yields a single "no match" result. At
// most 16 matches are reported. The result register lets a new request be
// accepted in the same cycle that a waiting result is taken.
// ---------------------------------------------------------------------------
module cron_job_table_matcher_top import cjtm_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  wire         clk,
  input  wire         rst,
  cjtm_req_if.sink    request,
  cjtm_rsp_if.source  result
);

  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t               state;
  logic [CW-1:0]        count;     // stored jobs
  logic [CW-1:0]        scan_idx;  // index of the flag now at cell 0
  logic [FOUND_W-1:0]   found;     // hits reported so far this tick
  logic                 pending_v; // a hit waits for its last mark
  logic [INDEX_W-1:0]   pending_idx;

  logic                 out_valid;
  cjtm_status_t         out_status;
  logic [INDEX_W-1:0]   out_idx;
  logic                 out_last;

  logic                 out_free;
  logic                 accept;
  logic                 add_write;
  logic                 full;
  logic                 scan_done;
  logic                 take_hit;
  logic                 shift;
  logic                 out_load;
  cjtm_status_t         out_status_next;
  logic [INDEX_W-1:0]   out_idx_next;
  logic                 out_last_next;

  cjtm_entry_t          din;
  cjtm_cell_ctl_t       ctl [MAX_JOBS];
  logic [MAX_JOBS:0]    hit_chain;

  assign out_free = !out_valid || result.ready;
  assign request.ready = (state == S_IDLE) && out_free;
  assign accept = request.valid && request.ready;
  assign full = (count == CW'(MAX_JOBS));
  assign add_write = accept && !request.req_type && !full;
  assign scan_done = (scan_idx == count) || (found == RES_LIMIT);

  // request fields double as the new entry and as the tick time
  assign din = '{minute:  request.minute_value,
                 hour:    request.hour_value,
                 dom:     request.day_of_month_value,
                 month:   request.month_value,
                 weekday: request.weekday_value,
                 action:  request.has_action};

  always_comb begin
    take_hit        = 1'b0;
    shift           = 1'b0;
    out_load        = 1'b0;
    out_status_next = ST_NONE;
    out_idx_next    = '0;
    out_last_next   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept && !request.req_type) begin
          out_load        = 1'b1;
          out_status_next = full ? ST_FULL : ST_ADDED;
          out_idx_next    = full ? '0 : INDEX_W'(count);
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          if (hit_chain[0]) begin
            // the held hit can go out only if the result slot is free
            if (!pending_v || out_free) begin
              take_hit        = 1'b1;
              shift           = 1'b1;
              out_load        = pending_v;
              out_status_next = ST_MATCH;
              out_idx_next    = pending_idx;
              out_last_next   = 1'b0;
            end
          end else begin
            shift = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = pending_v ? ST_MATCH : ST_NONE;
          out_idx_next    = pending_v ? pending_idx : '0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      found     <= '0;
      pending_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (add_write) begin
        count <= count + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && request.req_type) begin
            state     <= S_SCAN;
            scan_idx  <= '0;
            found     <= '0;
            pending_v <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_FINISH;
          end else if (shift) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (take_hit) begin
            pending_v <= 1'b1;
            found     <= found + FOUND_W'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state     <= S_IDLE;
            pending_v <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      pending_idx <= INDEX_W'(scan_idx);
    end
    if (out_load) begin
      out_status <= out_status_next;
      out_idx    <= out_idx_next;
      out_last   <= out_last_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.job_index = out_idx;
  assign result.last      = out_last;

  // cell row; flags move from cell i+1 to cell i
  assign hit_chain[MAX_JOBS] = 1'b0;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    assign ctl[i] = '{wr:    add_write && (count == CW'(i)),
                      load:  accept && request.req_type,
                      shift: shift};
    cjtm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[i]),
      .din     (din),
      .hit_in  (hit_chain[i+1]),
      .hit_out (hit_chain[i])
    );
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_JOBS))
    else $error("job count beyond table size");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    found <= RES_LIMIT)
    else $error("more matches than the result limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= count))
    else $error("scan ran past the stored jobs");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type) |=> (state == S_SCAN && scan_idx == '0))
    else $error("tick did not start a scan");

  a_none_only_empty: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_status_next == ST_NONE) |-> (!pending_v && found == '0))
    else $error("no-match result after a hit");
`endif

endmodule : cron_job_table_matcher_top
`default_nettype wire
